// ----- design/wdl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdl_pkg
// Shared types and constants of the word dictionary lookup core.
// ----------------------------------------------------------------------------
package wdl_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int MAX_WORD_LEN = 30;
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_MAIN   = 2'd1;
  localparam logic [1:0] ACT_IGN    = 2'd2;
  // unused code, behaves as a look up
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic [2:0] ST_KNOWN    = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_ADDED    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       match_is_main;
  } out_item_t;

  typedef logic [MAX_WORD_LEN-1:0][7:0] word_t;

  // finished word handed from front to back
  typedef struct packed {
    logic [1:0]       action;
    logic             ovf;
    logic [LEN_W-1:0] len;
    word_t            chars;
  } job_t;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] len;
    word_t            chars;
  } entry_t;

  typedef enum logic {
    B_IDLE,
    B_SCAN
  } b_state_t;

endpackage

// ----- design/wdl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdl_front
// Collects characters of a word and hands the finished word to the back end
// through a one-entry job slot.
// ----------------------------------------------------------------------------
module wdl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wdl_pkg::in_item_t in_item,
  output logic             job_vld,
  output wdl_pkg::job_t    job,
  input  logic             job_pop
);
  import wdl_pkg::*;

  word_t            buf_r, buf_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             slot_vld_r, slot_vld_nxt;
  job_t             slot_r, slot_nxt;
  logic             acc, store;

  assign busy    = slot_vld_r;
  assign job_vld = slot_vld_r;
  assign job     = slot_r;
  assign acc     = start && !busy;
  assign store   = !ovf_r && (len_r < LEN_W'(MAX_WORD_LEN));

  always_comb begin
    buf_nxt      = buf_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    slot_nxt     = slot_r;
    slot_vld_nxt = slot_vld_r && !job_pop;
    if (acc) begin
      if (store) begin
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
          if (LEN_W'(i) == len_r) buf_nxt[i] = in_item.char_code;
        end
        len_nxt = len_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_item.last_char) begin
        slot_nxt.action = in_item.action;
        slot_nxt.ovf    = ovf_nxt;
        slot_nxt.len    = len_nxt;
        slot_nxt.chars  = buf_nxt;
        slot_vld_nxt    = 1'b1;
        len_nxt         = '0;
        ovf_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    slot_r <= slot_nxt;
    if (!rst_n) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      slot_vld_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      slot_vld_r <= slot_vld_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_WORD_LEN)) else $error("word length past limit");
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    slot_vld_r && !job_pop |=> slot_vld_r && $stable(slot_r))
    else $error("job slot lost");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == LEN_W'(MAX_WORD_LEN)) else $error("overflow with room left");

endmodule

// ----- design/wdl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdl_back
// Entry table: appends added words, scans the entries for a look up until a main-list match or the table end.
// ----------------------------------------------------------------------------
module wdl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_vld,
  input  wdl_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_valid,
  output wdl_pkg::out_item_t out_item
);
  import wdl_pkg::*;

  entry_t           mem [MAX_ENTRIES];
  entry_t           rd_r;
  b_state_t         state_r, state_nxt;
  job_t             cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] raddr_r, raddr_nxt;
  logic             rvld_r, rvld_nxt;
  logic             ign_r, ign_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        oi_r, oi_nxt;
  logic             wr_en, rd_en, match, bytes_eq, scan_end;
  entry_t           wr_ent;

  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (LEN_W'(i) < cur_r.len && rd_r.chars[i] != cur_r.chars[i]) bytes_eq = 1'b0;
    end
  end

  assign match    = rvld_r && (rd_r.len == cur_r.len) && bytes_eq;
  assign scan_end = (raddr_r == cnt_r) && rvld_r;
  assign job_pop  = (state_r == B_IDLE) && job_vld;
  assign rd_en    = (state_r == B_SCAN) && (raddr_r < cnt_r);
  assign wr_en    = job_pop && !job.ovf && (job.action == ACT_MAIN || job.action == ACT_IGN)
                    && (cnt_r < CNT_W'(MAX_ENTRIES));
  assign wr_ent   = '{kind: (job.action == ACT_MAIN), len: job.len, chars: job.chars};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_pop && !job.ovf && !(job.action == ACT_MAIN || job.action == ACT_IGN)
            && cnt_r != '0) state_nxt = B_SCAN;
      end
      B_SCAN: begin
        if ((match && rd_r.kind) || scan_end) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    raddr_nxt = raddr_r;
    rvld_nxt  = 1'b0;
    ign_nxt   = ign_r;
    ov_nxt    = 1'b0;
    oi_nxt    = oi_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_pop) begin
          cur_nxt   = job;
          raddr_nxt = '0;
          ign_nxt   = 1'b0;
          oi_nxt    = '{status: ST_UNKNOWN, match_is_main: 1'b0};
          priority if (job.ovf) begin
            ov_nxt        = 1'b1;
            oi_nxt.status = ST_TOO_LONG;
          end else if (job.action == ACT_MAIN || job.action == ACT_IGN) begin
            ov_nxt        = 1'b1;
            oi_nxt.status = wr_en ? ST_ADDED : ST_FULL;
            if (wr_en) cnt_nxt = cnt_r + 1'b1;
          end else if (cnt_r == '0) begin
            ov_nxt = 1'b1;
          end
        end
      end
      B_SCAN: begin
        if (rd_en) begin
          raddr_nxt = raddr_r + 1'b1;
          rvld_nxt  = 1'b1;
        end
        if (match && !rd_r.kind) ign_nxt = 1'b1;
        priority if (match && rd_r.kind) begin
          rvld_nxt = 1'b0;
          ov_nxt   = 1'b1;
          oi_nxt   = '{status: ST_KNOWN, match_is_main: 1'b1};
        end else if (scan_end) begin
          ov_nxt = 1'b1;
          oi_nxt = (ign_r || match) ? '{status: ST_KNOWN, match_is_main: 1'b0}
                                    : '{status: ST_UNKNOWN, match_is_main: 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[ADDR_W-1:0]] <= wr_ent;
    if (rd_en) rd_r <= mem[raddr_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    raddr_r <= raddr_nxt;
    ign_r   <= ign_nxt;
    oi_r    <= oi_nxt;
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      rvld_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rvld_r  <= rvld_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES)) else $error("entry count past limit");
  a_raddr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_SCAN |-> raddr_r <= cnt_r) else $error("scan past table end");
  a_rvld: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> $past(state_r) == B_SCAN) else $error("read data outside scan");
  a_nowr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_SCAN |-> !wr_en) else $error("table written during scan");

endmodule

// ----- design/word_dictionary_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_dictionary_lookup_core
// Word table with append and exact-match lookup, fed one character per item.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while busy is low. The final character
// of a word moves it into a job slot; busy stays high while that slot is
// occupied, which is one cycle when the table unit is idle. An add is made
// by the table unit directly; a look up reads the single-port entry memory
// one entry per cycle, ending early on a main-list match. The next word can
// be gathered during a scan. Each result appears on out_item for one cycle
// with out_valid high and cannot be held off.
module word_dictionary_lookup_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  wdl_pkg::in_item_t  in_item,
  output logic               out_valid,
  output wdl_pkg::out_item_t out_item
);
  import wdl_pkg::*;

  logic job_vld, job_pop;
  job_t job;

  wdl_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .job_vld, .job, .job_pop
  );

  wdl_back u_back (
    .clk, .rst_n, .job_vld, .job, .job_pop,
    .out_valid, .out_item
  );

endmodule

// ----- bench/wdl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdl_checker
// Watches the character and result channels of the lookup core, keeps its own
// word table, predicts each result and compares it with the core's output.
// ----------------------------------------------------------------------------
module wdl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  wdl_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  wdl_pkg::out_item_t out_item,
  output int                 n_errors,
  output int                 n_pending
);
  import wdl_pkg::*;

  word_t            tbl_chars [MAX_ENTRIES];
  logic [LEN_W-1:0] tbl_len   [MAX_ENTRIES];
  logic             tbl_main  [MAX_ENTRIES];
  int               tbl_count;
  word_t            cur_word;
  int               cur_len;
  logic             cur_ovf;
  out_item_t        expected_q[$];

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    $display("[%0t] mismatch: %s got st=%0d main=%0d exp st=%0d main=%0d",
             $realtime, what, got.status, got.match_is_main, exp.status, exp.match_is_main);
    n_errors++;
  endtask

  // outcome of the word held in cur_word for the given action
  function automatic out_item_t finish_word(input logic [1:0] act);
    out_item_t r;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (cur_ovf) begin
      r.status = ST_TOO_LONG;
    end else if (act == ACT_MAIN || act == ACT_IGN) begin
      if (tbl_count >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        tbl_chars[tbl_count] = cur_word;
        tbl_len[tbl_count]   = LEN_W'(cur_len);
        tbl_main[tbl_count]  = (act == ACT_MAIN);
        tbl_count++;
        r.status = ST_ADDED;
      end
    end else begin
      r.status = ST_UNKNOWN;
      for (int e = 0; e < tbl_count; e++) begin
        if (tbl_len[e] != LEN_W'(cur_len)) continue;
        hit = 1'b1;
        for (int k = 0; k < cur_len; k++)
          if (tbl_chars[e][k] != cur_word[k]) hit = 1'b0;
        if (hit) begin
          r.status = ST_KNOWN;
          if (tbl_main[e]) r.match_is_main = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_count = 0;
      cur_len   = 0;
      cur_ovf   = 1'b0;
      n_errors  = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_item, '0);
        end else begin
          if (out_item !== expected_q[0]) report("result", out_item, expected_q[0]);
          void'(expected_q.pop_front());
        end
      end
      if (start && !busy) begin
        if (cur_ovf || cur_len >= MAX_WORD_LEN) begin
          cur_ovf = 1'b1;
        end else begin
          cur_word[cur_len] = in_item.char_code;
          cur_len++;
        end
        if (in_item.last_char) begin
          expected_q.push_back(finish_word(in_item.action));
          cur_len = 0;
          cur_ovf = 1'b0;
        end
      end
    end
    n_pending = expected_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds words to the lookup core: directed corner words, then random adds and
// look ups drawn from a small vocabulary, with random idle bursts; a full
// table phase fills the core. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import wdl_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        n_errors, n_pending;
  int        cycle_cnt = 0;
  int        n_items = 0;
  bit        idle_en = 1'b1;
  logic [7:0] vocab [16][MAX_WORD_LEN];
  int         vocab_len [16];

  always #5 clk = ~clk;

  word_dictionary_lookup_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  wdl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .n_errors(n_errors), .n_pending(n_pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 10000000) begin
      $display("word_dictionary_lookup_core regression: fail");
      $finish;
    end
  end

  // one character item; waits for acceptance
  task automatic send_char(input logic [1:0] act, input logic [7:0] ch, input logic last);
    int gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{action: act, char_code: ch, last_char: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
  endtask

  task automatic send_vocab(input int v, input logic [1:0] act);
    for (int k = 0; k < vocab_len[v] - 1; k++)
      send_char(2'($urandom_range(0, 3)), vocab[v][k], 1'b0);
    send_char(act, vocab[v][vocab_len[v]-1], 1'b1);
  endtask

  task automatic send_rand(input int len, input logic [1:0] act);
    for (int k = 1; k < len; k++)
      send_char(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
    send_char(act, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // the checker records an accepted item at the same edge, so wait for the next edge before reading n_pending
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  initial begin
    for (int v = 0; v < 16; v++) begin
      vocab_len[v] = (v == 0) ? 1 : (v == 15) ? MAX_WORD_LEN : $urandom_range(1, 6);
      for (int k = 0; k < MAX_WORD_LEN; k++) vocab[v][k] = 8'($urandom_range(0, 255));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send_char(ACT_LOOKUP, 8'h00, 1'b1);
    send_char(ACT_MAIN, 8'h00, 1'b1);
    send_char(ACT_LOOKUP, 8'h00, 1'b1);
    send_char(ACT_IGN, 8'hFF, 1'b1);
    send_char(ACT_SPARE, 8'hFF, 1'b1);
    send_char(ACT_MAIN, 8'hFF, 1'b1);
    send_char(ACT_LOOKUP, 8'hFF, 1'b1);
    send_rand(MAX_WORD_LEN, ACT_MAIN);
    send_rand(MAX_WORD_LEN + 1, ACT_LOOKUP);
    send_rand(MAX_WORD_LEN + 3, ACT_IGN);
    send_rand(MAX_WORD_LEN + 1, ACT_MAIN);
    send_char(ACT_LOOKUP, 8'hAA, 1'b0);
    send_char(ACT_LOOKUP, 8'h55, 1'b1);
    // random words from a small vocabulary so look ups hit
    while (n_items < 250) begin
      if ($urandom_range(0, 9) == 0)
        send_rand($urandom_range(1, MAX_WORD_LEN + 2), 2'($urandom_range(0, 3)));
      else
        send_vocab($urandom_range(0, 15),
                   ($urandom_range(0, 5) < 3) ? ACT_LOOKUP : 2'($urandom_range(1, 3)));
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
    idle_en = 1'b0;
    // fill the table, then exercise full and look ups over the whole table
    while (u_chk.tbl_count < MAX_ENTRIES)
      send_char(ACT_IGN, 8'($urandom_range(0, 255)), 1'b1);
    send_vocab(3, ACT_MAIN);
    send_vocab(3, ACT_IGN);
    send_rand(MAX_WORD_LEN + 1, ACT_MAIN);
    send_vocab(3, ACT_LOOKUP);
    send_vocab(15, ACT_LOOKUP);
    send_char(ACT_LOOKUP, 8'h5A, 1'b1);
    drain();
    repeat (MAX_ENTRIES + 20) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("word_dictionary_lookup_core regression: pass");
    end else begin
      $display("word_dictionary_lookup_core regression: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/wdl_pkg.sv
design/wdl_front.sv
design/wdl_back.sv
design/word_dictionary_lookup_core.sv
bench/wdl_checker.sv
bench/tb_top.sv
